@@ src/delta_list_task_scheduler_macros.svh @@
// Assertion macros for the delta list task scheduler.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef DELTA_LIST_TASK_SCHEDULER_MACROS_SVH
`define DELTA_LIST_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication
`define DLTS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DLTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dlts_pkg.sv @@
// Package for the delta list task scheduler: types, codes, stream widths
// and the microcode table. No dependencies.
`default_nettype none

package dlts_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;

  localparam int unsigned TAG_W       = 8;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned QCNT_W      = 5;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned UPC_W       = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_TICK     = 2'd1,
    OP_DISPATCH = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] delta;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_ADD_INIT,
    DP_INS_STEP,
    DP_INS_DONE,
    DP_TICK,
    DP_POP,
    DP_NEW_HEAD,
    DP_RESULT
  } dp_op_e;

  typedef enum logic [1:0] {
    RA_HEAD,
    RA_HEAD1,
    RA_K1
  } ra_sel_e;

  typedef enum logic [2:0] {
    JM_NEXT,
    JM_GOTO,
    JM_IF,
    JM_WAIT,
    JM_DECODE
  } jmp_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_FULL,
    C_EMPTY,
    C_NOT_SERVE,
    C_MORE,
    C_NO_PERIOD,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    dp_op_e  op;
    ra_sel_e ra;
    jmp_e    jm;
    cond_e   cond;
    upc_t    target;
  } ucode_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic not_serve;
    logic more;
    logic no_period;
    logic out_busy;
  } status_t;

  // microcode addresses
  localparam upc_t U_FETCH     = 4'd0;
  localparam upc_t U_ADD_CHK   = 4'd1;
  localparam upc_t U_ADD_GO    = 4'd2;
  localparam upc_t U_INS_LOOP  = 4'd3;
  localparam upc_t U_INS_DONE  = 4'd4;
  localparam upc_t U_TICK_CHK  = 4'd5;
  localparam upc_t U_TICK_WR   = 4'd6;
  localparam upc_t U_DSP_CHK   = 4'd7;
  localparam upc_t U_DSP_POP   = 4'd8;
  localparam upc_t U_DSP_NEW   = 4'd9;
  localparam upc_t U_DSP_REINS = 4'd10;
  localparam upc_t U_OUT       = 4'd11;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    w = '{op: DP_NOP, ra: RA_HEAD, jm: JM_GOTO, cond: C_NONE, target: U_FETCH};
    unique case (addr)
      U_FETCH: begin
        w.jm = JM_DECODE;
      end
      U_ADD_CHK: begin
        w.jm = JM_IF; w.cond = C_FULL; w.target = U_OUT;
      end
      U_ADD_GO: begin
        w.op = DP_ADD_INIT; w.jm = JM_NEXT;
      end
      U_INS_LOOP: begin
        w.op = DP_INS_STEP; w.ra = RA_K1;
        w.jm = JM_IF; w.cond = C_MORE; w.target = U_INS_LOOP;
      end
      U_INS_DONE: begin
        w.op = DP_INS_DONE; w.target = U_OUT;
      end
      U_TICK_CHK: begin
        w.jm = JM_IF; w.cond = C_EMPTY; w.target = U_OUT;
      end
      U_TICK_WR: begin
        w.op = DP_TICK; w.target = U_OUT;
      end
      U_DSP_CHK: begin
        w.jm = JM_IF; w.cond = C_NOT_SERVE; w.target = U_OUT;
      end
      U_DSP_POP: begin
        w.op = DP_POP; w.ra = RA_HEAD1; w.jm = JM_NEXT;
      end
      U_DSP_NEW: begin
        w.op = DP_NEW_HEAD; w.jm = JM_IF; w.cond = C_NO_PERIOD; w.target = U_OUT;
      end
      U_DSP_REINS: begin
        w.target = U_INS_LOOP;
      end
      U_OUT: begin
        w.op = DP_RESULT; w.jm = JM_WAIT; w.cond = C_OUT_BUSY; w.target = U_FETCH;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/delta_list_task_scheduler.sv @@
// Delta list task scheduler, top level: microcode sequencer plus datapath.
// Depends on dlts_pkg, dlts_seq, dlts_dp, delta_list_task_scheduler_macros.svh.
//
//  port group  dir   tdata / tuser contents (low bit first)
//  s_axis      in    tuser: opcode[1:0]; tdata: tag, delay, period
//  m_axis      out   tdata: add_accepted, run_valid, run_tag, queue_count, head_ready
//
// One item at a time. In an add, the insert walk reads and rewrites one
// queue RAM entry per cycle; a dispatch of a periodic task reinserts it
// with the same walk after the pop. The result register frees the input
// side; a stalled m_axis holds the sequencer in its output step. No
// clearing pass after reset.
`default_nettype none
`include "delta_list_task_scheduler_macros.svh"

module delta_list_task_scheduler #(
  parameter int unsigned MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: task_tag[7:0], delay_ticks[39:8], period_ticks[71:40]
  input  wire logic [dlts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: opcode[1:0]
  input  wire logic [dlts_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: add_accepted[0], run_valid[1], run_tag[9:2], queue_count[14:10],
  //        head_ready[15]
  output logic [dlts_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  import dlts_pkg::*;

  ucode_t  ctrl;
  status_t status;
  logic    in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  dlts_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (s_axis_tready)
  );

  dlts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_tag_i    (s_axis_tdata[TAG_W-1:0]),
    .in_delay_i  (s_axis_tdata[TAG_W+TICK_W-1:TAG_W]),
    .in_period_i (s_axis_tdata[TAG_W+2*TICK_W-1:TAG_W+TICK_W]),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

  `DLTS_ASSERT_NEXT(a_one_item, in_accept, !s_axis_tready, "input taken while busy")
  `DLTS_ASSERT_IMP(a_full_empty, 1'b1, !(status.full && status.empty), "queue full and empty")
  `DLTS_ASSERT_IMP(a_flags, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "add and run set")

endmodule

`default_nettype wire

@@ src/dlts_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module dlts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/dlts_seq.sv @@
// Microcode sequencer: step counter, control table lookup, jump logic.
// Depends on dlts_pkg.
`default_nettype none

module dlts_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        opcode_i,
  input  wire dlts_pkg::status_t status_i,
  output dlts_pkg::ucode_t       ctrl_o,
  output logic                   in_ready_o
);

  import dlts_pkg::*;

  upc_t   upc_q, upc_d;
  ucode_t uw;
  logic   cond_hit;

  assign uw = ucode_rom(upc_q);

  always_comb begin
    unique case (uw.cond)
      C_NONE:      cond_hit = 1'b0;
      C_FULL:      cond_hit = status_i.full;
      C_EMPTY:     cond_hit = status_i.empty;
      C_NOT_SERVE: cond_hit = status_i.not_serve;
      C_MORE:      cond_hit = status_i.more;
      C_NO_PERIOD: cond_hit = status_i.no_period;
      C_OUT_BUSY:  cond_hit = status_i.out_busy;
      default:     cond_hit = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    upc_d = upc_q + UPC_W'(1);
    unique case (uw.jm)
      JM_NEXT: upc_d = upc_q + UPC_W'(1);
      JM_GOTO: upc_d = uw.target;
      JM_IF:   upc_d = cond_hit ? uw.target : upc_q + UPC_W'(1);
      JM_WAIT: upc_d = cond_hit ? upc_q : uw.target;
      JM_DECODE: begin
        if (!in_valid_i) begin
          upc_d = upc_q;
        end else begin
          unique case (opcode_e'(opcode_i))
            OP_ADD:      upc_d = U_ADD_CHK;
            OP_TICK:     upc_d = U_TICK_CHK;
            OP_DISPATCH: upc_d = U_DSP_CHK;
            default:     upc_d = U_OUT;
          endcase
        end
      end
      default: upc_d = U_FETCH;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o     = uw;
    in_ready_o = (uw.jm == JM_DECODE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

@@ src/dlts_dp.sv @@
// Datapath: queue RAM (circular, head pointer), insert walk registers,
// head ready flag and the result register. Depends on dlts_pkg, dlts_ram.
`default_nettype none

module dlts_dp #(
  parameter int unsigned MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_accept_i,
  input  wire logic [dlts_pkg::TAG_W-1:0]         in_tag_i,
  input  wire logic [dlts_pkg::TICK_W-1:0]        in_delay_i,
  input  wire logic [dlts_pkg::TICK_W-1:0]        in_period_i,
  input  wire dlts_pkg::ucode_t                   ctrl_i,
  output dlts_pkg::status_t                       status_o,
  output logic                                    m_tvalid_o,
  input  wire logic                               m_tready_i,
  output logic [dlts_pkg::OUT_TDATA_W-1:0]        m_tdata_o
);

  import dlts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W:0] SUM_ONE = (IDX_W+1)'(1);
  localparam logic [IDX_W:0] SUM_LIM = (IDX_W+1)'(MAX_TASKS);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  function automatic idx_t wrap_slot(input logic [IDX_W:0] sum);
    if (sum >= SUM_LIM) begin
      return IDX_W'(sum - SUM_LIM);
    end
    return IDX_W'(sum);
  endfunction

  idx_t  head_q, head_d, k_q, k_d;
  cnt_t  count_q, count_d;
  logic  placed_q, placed_d, hready_q, hready_d;
  logic  out_valid_q, out_valid_d;
  logic  [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic  [TAG_W-1:0]  ins_tag_q, ins_tag_d, run_tag_q, run_tag_d;
  logic  [TICK_W-1:0] ins_delay_q, ins_delay_d, ins_period_q, ins_period_d;
  logic  [TICK_W-1:0] delta_dec;
  entry_t carry_q, carry_d, rd, wdata;
  logic  add_acc_q, add_acc_d, run_valid_q, run_valid_d;
  logic  we, at_end, out_busy, head_flag;
  idx_t  waddr, raddr, slot_k, slot_k1, slot_h1;
  logic  [$bits(entry_t)-1:0] ram_rdata;

  dlts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign rd        = entry_t'(ram_rdata);
  assign at_end    = (cnt_t'(k_q) == count_q);
  assign slot_k    = wrap_slot({1'b0, head_q} + {1'b0, k_q});
  assign slot_k1   = wrap_slot({1'b0, head_q} + {1'b0, k_q} + SUM_ONE);
  assign slot_h1   = wrap_slot({1'b0, head_q} + SUM_ONE);
  assign delta_dec = (rd.delta == '0) ? '0 : rd.delta - TICK_W'(1);
  assign out_busy  = out_valid_q && !m_tready_i;
  assign head_flag = (count_q != '0) && hready_q;

  always_comb begin
    unique case (ctrl_i.ra)
      RA_HEAD:  raddr = head_q;
      RA_HEAD1: raddr = slot_h1;
      RA_K1:    raddr = slot_k1;
      default:  raddr = head_q;
    endcase
  end

  always_comb begin
    status_o.full      = (count_q == CNT_W'(MAX_TASKS));
    status_o.empty     = (count_q == '0);
    status_o.not_serve = (count_q == '0) || !hready_q;
    status_o.more      = !at_end;
    status_o.no_period = (ins_period_q == '0);
    status_o.out_busy  = out_busy;
  end

  always_comb begin
    head_d       = head_q;
    k_d          = k_q;
    count_d      = count_q;
    placed_d     = placed_q;
    hready_d     = hready_q;
    ins_tag_d    = ins_tag_q;
    ins_delay_d  = ins_delay_q;
    ins_period_d = ins_period_q;
    carry_d      = carry_q;
    add_acc_d    = add_acc_q;
    run_valid_d  = run_valid_q;
    run_tag_d    = run_tag_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    we           = 1'b0;
    waddr        = slot_k;
    wdata        = carry_q;

    if (in_accept_i) begin
      ins_tag_d    = in_tag_i;
      ins_delay_d  = in_delay_i;
      ins_period_d = in_period_i;
      add_acc_d    = 1'b0;
      run_valid_d  = 1'b0;
      run_tag_d    = '0;
    end

    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (ctrl_i.op)
      DP_NOP: ;
      DP_ADD_INIT: begin
        k_d       = '0;
        placed_d  = 1'b0;
        add_acc_d = 1'b1;
      end
      DP_INS_STEP: begin
        k_d = k_q + IDX_W'(1);
        if (placed_q) begin
          // ripple: previous entry moves up one slot
          we      = 1'b1;
          carry_d = rd;
        end else if (at_end || ins_delay_q <= rd.delta) begin
          we       = 1'b1;
          wdata    = '{period: ins_period_q, delta: ins_delay_q, tag: ins_tag_q};
          placed_d = 1'b1;
          carry_d  = '{period: rd.period, delta: rd.delta - ins_delay_q, tag: rd.tag};
          if (k_q == '0) begin
            hready_d = 1'b0;
          end
        end else begin
          ins_delay_d = ins_delay_q - rd.delta;
        end
      end
      DP_INS_DONE: begin
        count_d = count_q + CNT_W'(1);
      end
      DP_TICK: begin
        we       = 1'b1;
        waddr    = head_q;
        wdata    = '{period: rd.period, delta: delta_dec, tag: rd.tag};
        hready_d = (delta_dec == '0);
      end
      DP_POP: begin
        run_valid_d  = 1'b1;
        run_tag_d    = rd.tag;
        ins_tag_d    = rd.tag;
        ins_delay_d  = rd.period;
        ins_period_d = rd.period;
        head_d       = slot_h1;
        count_d      = count_q - CNT_W'(1);
      end
      DP_NEW_HEAD: begin
        hready_d = (count_q != '0) && (rd.delta == '0);
        k_d      = '0;
        placed_d = 1'b0;
      end
      DP_RESULT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_data_d  = {head_flag, QCNT_W'(count_q), run_tag_q, run_valid_q, add_acc_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      k_q         <= '0;
      count_q     <= '0;
      placed_q    <= 1'b0;
      hready_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      k_q         <= k_d;
      count_q     <= count_d;
      placed_q    <= placed_d;
      hready_q    <= hready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_tag_q    <= ins_tag_d;
    ins_delay_q  <= ins_delay_d;
    ins_period_q <= ins_period_d;
    carry_q      <= carry_d;
    add_acc_q    <= add_acc_d;
    run_valid_q  <= run_valid_d;
    run_tag_q    <= run_tag_d;
    out_data_q   <= out_data_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

`default_nettype wire

@@ bench/delta_list_task_scheduler_test.sv @@
// Self-checking bench for delta_list_task_scheduler: directed rows, then mixed
// random add/tick/dispatch/unused-opcode traffic, checked against an in-bench delta list.
// Depends on dlts_pkg and the scheduler RTL.
module delta_list_task_scheduler_test;
  import dlts_pkg::*;

  localparam int unsigned QDEPTH       = MAX_TASKS_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned HOLD_AFTER   = 600;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned PHASE_LEN    = 64;
  localparam int unsigned MAX_PERIODIC = 5;

  // packed so that it lines up with m_axis_tdata
  typedef struct packed {
    logic              head_ready;
    logic [QCNT_W-1:0] queue_count;
    logic [TAG_W-1:0]  run_tag;
    logic              run_valid;
    logic              add_accepted;
  } sched_status_t;

  typedef struct {
    logic [1:0]        op;
    logic [TAG_W-1:0]  tag;
    logic [TICK_W-1:0] delay;
    logic [TICK_W-1:0] period;
    bit                typed;
    sched_status_t     want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata: task_tag[7:0], delay_ticks[39:8], period_ticks[71:40]
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // tuser: opcode[1:0]
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata: add_accepted[0], run_valid[1], run_tag[9:2], queue_count[14:10],
  //        head_ready[15]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  delta_list_task_scheduler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow delta list
  logic [TAG_W-1:0]  q_tag    [QDEPTH];
  logic [TICK_W-1:0] q_delta  [QDEPTH];
  logic [TICK_W-1:0] q_period [QDEPTH];
  bit                q_ready  [QDEPTH];
  int                q_len;

  sched_status_t pending_status[$];
  stim_row_t     rows[$];
  sched_status_t mon_want;
  sched_status_t mon_got;

  int fail_count;
  int n_items;
  int n_served;
  int n_refused;
  int peak_len;
  int idle_cycles;

  int fill_delay[14] = '{3, 3, 0, 7, 1, 12, 3, 20, 0, 5, 2, 9, 4, 6};

  function automatic bit sched_insert(input logic [TAG_W-1:0] tag,
                                      input logic [TICK_W-1:0] delay,
                                      input logic [TICK_W-1:0] period);
    int pos;
    int k;
    logic [TICK_W-1:0] rem;
    pos = 0;
    rem = delay;
    if (q_len >= QDEPTH) return 1'b0;
    while (pos < q_len && rem > q_delta[pos]) begin
      rem = rem - q_delta[pos];
      pos++;
    end
    for (k = q_len; k > pos; k--) begin
      q_tag[k]    = q_tag[k-1];
      q_delta[k]  = q_delta[k-1];
      q_period[k] = q_period[k-1];
      q_ready[k]  = q_ready[k-1];
    end
    q_tag[pos]    = tag;
    q_delta[pos]  = rem;
    q_period[pos] = period;
    q_ready[pos]  = 1'b0;
    q_len++;
    if (pos + 1 < q_len) q_delta[pos+1] = q_delta[pos+1] - rem;
    return 1'b1;
  endfunction

  function automatic void sched_pop();
    int k;
    for (k = 0; k + 1 < q_len; k++) begin
      q_tag[k]    = q_tag[k+1];
      q_delta[k]  = q_delta[k+1];
      q_period[k] = q_period[k+1];
      q_ready[k]  = q_ready[k+1];
    end
    q_len--;
    q_ready[q_len] = 1'b0;
  endfunction

  function automatic sched_status_t sched_apply(input logic [1:0] op,
                                                input logic [TAG_W-1:0] tag,
                                                input logic [TICK_W-1:0] delay,
                                                input logic [TICK_W-1:0] period);
    sched_status_t r;
    logic [TAG_W-1:0] served;
    logic [TICK_W-1:0] per;
    r = '0;
    case (op)
      OP_ADD: begin
        r.add_accepted = sched_insert(tag, delay, period);
      end
      OP_TICK: begin
        if (q_len > 0) begin
          if (q_delta[0] > 0) q_delta[0] = q_delta[0] - 1;
          if (q_delta[0] == 0) q_ready[0] = 1'b1;
        end
      end
      OP_DISPATCH: begin
        if (q_len > 0 && q_ready[0]) begin
          served = q_tag[0];
          per = q_period[0];
          r.run_valid = 1'b1;
          r.run_tag = served;
          sched_pop();
          if (q_len > 0 && q_delta[0] == 0) q_ready[0] = 1'b1;
          if (per > 0) void'(sched_insert(served, per, per));
        end
      end
      default: ;
    endcase
    r.queue_count = QCNT_W'(q_len);
    r.head_ready = (q_len > 0) && q_ready[0];
    return r;
  endfunction

  function automatic sched_status_t status_of(input int acc, input int rv,
                                              input logic [TAG_W-1:0] tag,
                                              input int cnt, input int hr);
    sched_status_t s;
    s.add_accepted = 1'(acc);
    s.run_valid = 1'(rv);
    s.run_tag = tag;
    s.queue_count = QCNT_W'(cnt);
    s.head_ready = 1'(hr);
    return s;
  endfunction

  function automatic stim_row_t drow(input logic [1:0] op, input logic [TAG_W-1:0] tag,
                                     input logic [TICK_W-1:0] delay,
                                     input logic [TICK_W-1:0] period,
                                     input bit typed, input sched_status_t want);
    stim_row_t r;
    r.op = op;
    r.tag = tag;
    r.delay = delay;
    r.period = period;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  task automatic send_item(input stim_row_t it);
    sched_status_t got;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.op;
    s_axis_tdata  = {it.period, it.delay, it.tag};
    do @(posedge clk_i); while (!s_axis_tready);
    got = sched_apply(it.op, it.tag, it.delay, it.period);
    pending_status.push_back(it.typed ? it.want : got);
    n_items++;
    if (got.run_valid) n_served++;
    if (it.op == OP_ADD && !got.add_accepted) n_refused++;
    if (q_len > peak_len) peak_len = q_len;
  endtask

  task automatic hold_input(input int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_status.size() == 0) begin
        $error("result transfer with nothing pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        mon_want = pending_status.pop_front();
        mon_got  = sched_status_t'(m_axis_tdata);
        check_field("add_accepted", 32'(mon_want.add_accepted), 32'(mon_got.add_accepted));
        check_field("run_valid", 32'(mon_want.run_valid), 32'(mon_got.run_valid));
        check_field("run_tag", 32'(mon_want.run_tag), 32'(mon_got.run_tag));
        check_field("queue_count", 32'(mon_want.queue_count), 32'(mon_got.queue_count));
        check_field("head_ready", 32'(mon_want.head_ready), 32'(mon_got.head_ready));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[delta_list_task_scheduler] ERROR");
      $finish;
    end
  end

  // receiver: random stall pattern plus one long hold-off
  initial begin : receiver
    bit held;
    int seg_len;
    int style;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && n_items >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          m_axis_tready = 1'b0;
        end
      end else begin
        seg_len = $urandom_range(1, 40);
        style = $urandom_range(0, 2);
        repeat (seg_len) begin
          @(negedge clk_i);
          case (style)
            0:       m_axis_tready = 1'b1;
            1:       m_axis_tready = 1'($urandom_range(0, 1));
            default: m_axis_tready = ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t it;
    int i;
    int total;
    int burst_left;
    int r;
    int w_add;
    int w_tick;
    int n_periodic;
    int k;

    fail_count = 0;
    n_items = 0;
    n_served = 0;
    n_refused = 0;
    peak_len = 0;
    q_len = 0;
    for (k = 0; k < QDEPTH; k++) q_ready[k] = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;

    // empty queue, no-ops
    rows.push_back(drow(OP_TICK, 8'h00, 32'h0, 32'h0, 1'b1, status_of(0, 0, 8'h00, 0, 0)));
    rows.push_back(drow(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 1'b1,
                        status_of(0, 0, 8'h00, 0, 0)));
    rows.push_back(drow(OP_UNUSED, 8'hA5, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
                        status_of(0, 0, 8'h00, 0, 0)));
    // extremes: tail add without successor, then zero delay in front
    rows.push_back(drow(OP_ADD, 8'hFF, 32'hFFFFFFFF, 32'h0, 1'b1,
                        status_of(1, 0, 8'h00, 1, 0)));
    rows.push_back(drow(OP_ADD, 8'h00, 32'h0, 32'hFFFFFFFF, 1'b1,
                        status_of(1, 0, 8'h00, 2, 0)));
    // head at zero: ready, stays ready on repeated ticks
    rows.push_back(drow(OP_TICK, 8'h00, 32'h0, 32'h0, 1'b1, status_of(0, 0, 8'h00, 2, 1)));
    rows.push_back(drow(OP_TICK, 8'h00, 32'h0, 32'h0, 1'b1, status_of(0, 0, 8'h00, 2, 1)));
    // zero delay ahead of a ready head: new head not ready
    rows.push_back(drow(OP_ADD, 8'h55, 32'h0, 32'h0, 1'b1, status_of(1, 0, 8'h00, 3, 0)));
    rows.push_back(drow(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 1'b1,
                        status_of(0, 0, 8'h00, 3, 0)));
    rows.push_back(drow(OP_TICK, 8'h00, 32'h0, 32'h0, 1'b1, status_of(0, 0, 8'h00, 3, 1)));
    rows.push_back(drow(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 1'b1,
                        status_of(0, 1, 8'h55, 2, 1)));
    // periodic head, reinserted after the pop
    rows.push_back(drow(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 1'b0, '0));
    // fill up, then one refused add
    for (k = 0; k < 14; k++)
      rows.push_back(drow(OP_ADD, TAG_W'(8'h10 + k), fill_delay[k],
                          (k == 4) ? 32'd2 : (k == 9) ? 32'd5 : 32'd0, 1'b0, '0));
    rows.push_back(drow(OP_ADD, 8'hC3, 32'd1, 32'd0, 1'b1, status_of(0, 0, 8'h00, 16, 0)));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    total = rows.size() + RANDOM_ITEMS;
    burst_left = 0;
    w_add = 34;
    w_tick = 33;
    for (i = 0; i < total; i++) begin
      if (burst_left == 0) begin
        hold_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      if (i < rows.size()) begin
        it = rows[i];
      end else begin
        if ((i - rows.size()) % PHASE_LEN == 0) begin
          case ($urandom_range(0, 2))
            0:       begin w_add = 60; w_tick = 20; end
            1:       begin w_add = 10; w_tick = 45; end
            default: begin w_add = 34; w_tick = 33; end
          endcase
        end
        n_periodic = 0;
        for (k = 0; k < q_len; k++) if (q_period[k] != 0) n_periodic++;
        it.typed = 1'b0;
        it.want = '0;
        it.tag = TAG_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r == 0) it.op = OP_UNUSED;
        else if (r <= w_add) it.op = OP_ADD;
        else if (r <= w_add + w_tick) it.op = OP_TICK;
        else it.op = OP_DISPATCH;
        r = $urandom_range(0, 99);
        if (r < 70) it.delay = $urandom_range(0, 6);
        else if (r < 92) it.delay = $urandom_range(0, 40);
        else if (r < 97 || q_len >= 8) it.delay = $urandom_range(0, 2);
        else it.delay = $urandom;
        r = $urandom_range(0, 99);
        if (n_periodic < MAX_PERIODIC && r < 25) begin
          r = $urandom_range(0, 99);
          if (r < 80) it.period = $urandom_range(1, 10);
          else if (r < 95) it.period = $urandom_range(11, 1000);
          else it.period = $urandom;
        end else begin
          it.period = $urandom_range(0, 3) == 0 ? 32'd0 : 32'd0;
        end
      end
      send_item(it);
    end
    hold_input(1);

    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d items: %0d tasks dispatched, %0d adds refused when full,",
             n_items, n_served, n_refused);
    $display("peak occupancy %0d of %0d, one long output hold-off", peak_len, QDEPTH);
    if (fail_count == 0)
      $display("[delta_list_task_scheduler] OK");
    else
      $display("[delta_list_task_scheduler] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/dlts_pkg.sv
src/dlts_ram.sv
src/dlts_seq.sv
src/dlts_dp.sv
src/delta_list_task_scheduler.sv
bench/delta_list_task_scheduler_test.sv
